@@ hw/rtl/lkv_pkg.sv @@
// Shared types and codes for the key-value cache.
package lkv_pkg;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int STAMP_W = 64;
	localparam int ACT_W   = 5;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_ACCESS = 1'b1;

	// Word address bit of the register file (one register at byte 0)
	localparam logic REG_ACTIVE = 1'b0;

	localparam logic [ACT_W-1:0]   ACTIVE_RESET = 5'd16;
	localparam logic [STAMP_W-1:0] STAMP_RESET  = 64'd1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic match;
		logic free;
		logic oldest;
	} scan_flags_t;

endpackage

@@ hw/rtl/lru_key_value_cache.sv @@
// Top level of the fully associative key-value cache with LRU replacement.
//
//  channel   | transfer when                         | payload
//  ----------+---------------------------------------+--------------------------
//  command   | start & !busy at rising edge          | opcode, key, value
//  result    | result_valid high for one cycle       | hit, read_value
//  config    | psel & penable & pwrite (pready = 1)  | paddr, pwdata -> prdata
//
// A command passes through the states idle (take the transfer), scan (n memory
// reads of the entry store, n = min(active_entries, ENTRIES), one read port, one
// entry a cycle), drain (the last read) and commit (write back). The result strobe
// follows in the next cycle, when busy is already low and a new command can be taken.
// With no active entries busy never rises; an access shows its miss in the next cycle.
// Reset clears all valid bits at once, sets the stamp counter to one and the
// active count to 16; the store itself needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lru_key_value_cache
	import lkv_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [KEY_W-1:0]   key,
	input  logic [VALUE_W-1:0] value,
	// result channel
	output logic               result_valid,
	output logic               hit,
	output logic [VALUE_W-1:0] read_value,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = CNT_W + ACT_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t state_q;

	logic [ACT_W-1:0]   active_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [ENTRIES-1:0] valid_q;

	logic               op_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;

	logic [IDX_W-1:0]   ptr_q;
	logic               eval_s1;
	logic [IDX_W-1:0]   eval_idx_s1;
	logic               eval_valid_s1;

	logic               result_valid_q;
	logic               hit_q;
	logic [VALUE_W-1:0] read_value_q;

	// Live entry count: saturate the register to the store depth
	logic [CMP_W-1:0] act_wide;
	logic [CNT_W-1:0] live_n;
	logic             last_issue;
	logic             accept;
	logic             cfg_write;

	assign act_wide   = CMP_W'(active_q);
	assign live_n     = (act_wide > CMP_W'(ENTRIES)) ? CNT_W'(ENTRIES) : act_wide[CNT_W-1:0];
	assign last_issue = (CNT_W'(ptr_q) == (live_n - CNT_W'(1)));
	assign accept     = start && (state_q == ST_IDLE);
	assign cfg_write  = psel && penable && pwrite;

	// Entry store and scan tracker
	entry_t             rd_data;
	logic               mem_re;
	logic               mem_we;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_data;
	scan_flags_t        flags;
	logic [IDX_W-1:0]   match_idx;
	logic [VALUE_W-1:0] match_value;
	logic [IDX_W-1:0]   free_idx;
	logic [IDX_W-1:0]   oldest_idx;

	assign mem_re = (state_q == ST_SCAN);

	lkv_mem #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_re),
		.rd_addr (ptr_q),
		.rd_data (rd_data),
		.wr_en   (mem_we),
		.wr_addr (wr_idx),
		.wr_data (wr_data)
	);

	lkv_scan #(
		.IDX_W (IDX_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (accept),
		.in_valid    (eval_s1),
		.in_idx      (eval_idx_s1),
		.ent_valid   (eval_valid_s1),
		.ent         (rd_data),
		.key         (key_q),
		.flags       (flags),
		.match_idx   (match_idx),
		.match_value (match_value),
		.free_idx    (free_idx),
		.oldest_idx  (oldest_idx)
	);

	// Write-back of an add: update a match, else fill the lowest free entry, else evict the oldest.
	// An access that hits rewrites its own entry with a fresh stamp.
	always_comb begin
		mem_we        = 1'b0;
		wr_idx        = oldest_idx;
		wr_data.key   = key_q;
		wr_data.value = value_q;
		wr_data.stamp = stamp_q;
		if (state_q == ST_COMMIT) begin
			if (op_q == OP_ADD) begin
				mem_we = 1'b1;
				if (flags.match) begin
					wr_idx = match_idx;
				end else if (flags.free) begin
					wr_idx = free_idx;
				end
			end else begin
				mem_we        = flags.match;
				wr_idx        = match_idx;
				wr_data.value = match_value;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ptr_q          <= '0;
			eval_s1        <= 1'b0;
			result_valid_q <= 1'b0;
			stamp_q        <= STAMP_RESET;
			valid_q        <= '0;
		end else begin
			result_valid_q <= 1'b0;
			eval_s1        <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ptr_q <= '0;
						if (live_n != '0) begin
							state_q <= ST_SCAN;
						end else if (opcode == OP_ACCESS) begin
							// nothing in use: report a miss at once
							result_valid_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					eval_s1 <= 1'b1;
					ptr_q   <= ptr_q + IDX_W'(1);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
					if (op_q == OP_ACCESS) begin
						result_valid_q <= 1'b1;
					end
					if (mem_we) begin
						valid_q[wr_idx] <= 1'b1;
						stamp_q         <= stamp_q + STAMP_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command latch, read tagging and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			key_q   <= key;
			value_q <= value;
			hit_q        <= 1'b0;
			read_value_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			eval_idx_s1   <= ptr_q;
			eval_valid_s1 <= valid_q[ptr_q];
		end
		if (state_q == ST_COMMIT) begin
			hit_q        <= flags.match;
			read_value_q <= flags.match ? match_value : '0;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_write && (paddr[2] == REG_ACTIVE)) begin
			active_q <= pwdata[ACT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_ACTIVE) ? 32'(active_q) : '0;
	assign pready = 1'b1;

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign hit          = hit_q;
	assign read_value   = read_value_q;

	// A result leaves with the sequencer free to take the next command
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while busy");

	// The stamp moves by one, and only on a write-back
	a_stamp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(stamp_q != $past(stamp_q)) |->
			((stamp_q == $past(stamp_q) + STAMP_W'(1)) && $past(state_q == ST_COMMIT)))
		else $error("stamp counter moved out of turn");

	// Busy rises only on a taken command
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without command");

	// A written entry is valid afterwards
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> valid_q[$past(wr_idx)])
		else $error("written entry not marked valid");

endmodule

@@ hw/rtl/lkv_mem.sv @@
// Entry store: one write port, one read port with registered read data.
module lkv_mem
	import lkv_pkg::*;
#(
	parameter int ENTRIES = 16,
	parameter int IDX_W   = 4
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data
);

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/lkv_scan.sv @@
// Scan tracker: first match, first free entry and oldest valid entry.
module lkv_scan
	import lkv_pkg::*;
#(
	parameter int IDX_W = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear,
	input  logic               in_valid,
	input  logic [IDX_W-1:0]   in_idx,
	input  logic               ent_valid,
	input  entry_t             ent,
	input  logic [KEY_W-1:0]   key,
	output scan_flags_t        flags,
	output logic [IDX_W-1:0]   match_idx,
	output logic [VALUE_W-1:0] match_value,
	output logic [IDX_W-1:0]   free_idx,
	output logic [IDX_W-1:0]   oldest_idx
);

	scan_flags_t        flags_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic [VALUE_W-1:0] match_value_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [IDX_W-1:0]   oldest_idx_q;
	logic [STAMP_W-1:0] oldest_stamp_q;

	logic hit_now;
	logic free_now;
	logic older_now;

	// Keep the lowest index on ties: only a strictly smaller stamp wins
	assign hit_now   = in_valid && ent_valid && (ent.key == key) && !flags_q.match;
	assign free_now  = in_valid && !ent_valid && !flags_q.free;
	assign older_now = in_valid && ent_valid &&
		(!flags_q.oldest || (ent.stamp < oldest_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clear) begin
			flags_q <= '0;
		end else begin
			if (hit_now) flags_q.match <= 1'b1;
			if (free_now) flags_q.free <= 1'b1;
			if (older_now) flags_q.oldest <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_now) begin
			match_idx_q   <= in_idx;
			match_value_q <= ent.value;
		end
		if (free_now) begin
			free_idx_q <= in_idx;
		end
		if (older_now) begin
			oldest_idx_q   <= in_idx;
			oldest_stamp_q <= ent.stamp;
		end
	end

	assign flags       = flags_q;
	assign match_idx   = match_idx_q;
	assign match_value = match_value_q;
	assign free_idx    = free_idx_q;
	assign oldest_idx  = oldest_idx_q;

endmodule
